// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int ID_W   = 7;
    localparam int LEFT_W = 12;
    localparam int TIME_W = 19;

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEFT_W-1:0] left;
    } entry_t;

    typedef struct packed {
        logic              load_accepted;
        logic              ran_valid;
        logic [ID_W-1:0]   ran_id;
        logic [LEFT_W-1:0] ran_left;
        logic              done_valid;
        logic [ID_W-1:0]   done_id;
        logic [TIME_W-1:0] done_time;
        logic              all_idle;
    } result_t;

endpackage

// ===== rtl/rrts_in_if.sv =====
`timescale 1ns / 1ps

interface rrts_in_if;
    import rrts_pkg::*;

    logic              valid;
    logic              ready;
    logic [0:0]        opcode;
    logic [ID_W-1:0]   task_id;
    logic [LEFT_W-1:0] burst_len;

    modport source (output valid, output opcode, output task_id, output burst_len, input ready);
    modport sink   (input valid, input opcode, input task_id, input burst_len, output ready);
endinterface

// ===== rtl/rrts_out_if.sv =====
`timescale 1ns / 1ps

interface rrts_out_if;
    import rrts_pkg::*;

    logic              valid;
    logic              ready;
    logic              load_accepted;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic [LEFT_W-1:0] ran_left;
    logic              done_valid;
    logic [ID_W-1:0]   done_id;
    logic [TIME_W-1:0] done_time;
    logic              all_idle;

    modport source (
        output valid, output load_accepted, output ran_valid, output ran_id,
        output ran_left, output done_valid, output done_id, output done_time,
        output all_idle, input ready
    );
    modport sink (
        input valid, input load_accepted, input ran_valid, input ran_id,
        input ran_left, input done_valid, input done_id, input done_time,
        input all_idle, output ready
    );
endinterface

// ===== rtl/round_robin_tick_scheduler.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Beat
// -------  ---  ---------------------------------------------------------
// cmd      in   opcode, task_id, burst_len (load a task or one tick)
// res      out  load_accepted, ran_*, done_*, all_idle (one per cmd beat)
//
// One cmd beat per cycle while res is not stalled; its result sits in the output register the cycle after.
// The ring is a single-port-write memory with a registered read of the next head,
// so a pop and a push fit in the same cycle.
// Reset is asynchronous and clears control state only; the ring needs no clearing pass.
// While res is stalled with a beat held, cmd.ready stays low.

module round_robin_tick_scheduler #(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_BURST   = 3600
) (
    input  logic       clk,
    input  logic       rst_n,
    rrts_in_if.sink    cmd,
    rrts_out_if.source res
);
    import rrts_pkg::*;

    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_LEFT = (1 << LEFT_W) - 1;
    localparam int MAX_CLIP = (MAX_BURST > MAX_LEFT) ? MAX_LEFT : MAX_BURST;

    entry_t            ring_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              run_valid_reg, run_valid_next;
    logic [ID_W-1:0]   run_id_reg, run_id_next;
    logic [LEFT_W-1:0] run_left_reg, run_left_next;
    logic [TIME_W-1:0] run_stamp_reg, run_stamp_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    entry_t            rd_data_reg;
    logic              byp_reg;
    entry_t            byp_data_reg;
    logic              res_valid_reg, res_valid_next;
    result_t           res_data_reg, res_data_next;

    logic              take;
    logic              push, pop;
    entry_t            push_ent;
    entry_t            head_ent;
    entry_t            nxt;
    logic              have_next;
    logic              run_done;
    logic              ring_empty, ring_full;
    logic [LEFT_W-1:0] burst_min1;
    logic [LEFT_W-1:0] left_dec;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign cmd.ready  = !res_valid_reg || res.ready;
    assign take       = cmd.valid && cmd.ready;
    assign ring_empty = (count_reg == '0);
    assign ring_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_ent   = byp_reg ? byp_data_reg : rd_data_reg;
    assign run_done   = run_valid_reg && (run_left_reg == '0);
    assign burst_min1 = (cmd.burst_len == '0) ? LEFT_W'(1) : cmd.burst_len;
    assign left_dec   = (nxt.left != '0) ? nxt.left - LEFT_W'(1) : nxt.left;

    always_comb
    begin
        push           = 1'b0;
        pop            = 1'b0;
        push_ent       = '0;
        nxt            = '0;
        have_next      = 1'b0;
        tick_next      = tick_reg;
        run_valid_next = run_valid_reg;
        run_id_next    = run_id_reg;
        run_left_next  = run_left_reg;
        run_stamp_next = run_stamp_reg;
        res_data_next  = '0;

        if (take)
        begin
            unique case (opcode_t'(cmd.opcode))
                OP_LOAD:
                begin
                    if (!ring_full)
                    begin
                        push          = 1'b1;
                        push_ent.id   = cmd.task_id;
                        push_ent.left = (burst_min1 > LEFT_W'(MAX_CLIP)) ?
                                        LEFT_W'(MAX_CLIP) : burst_min1;
                        res_data_next.load_accepted = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    tick_next = tick_reg + TIME_W'(1);
                    if (run_done)
                    begin
                        res_data_next.done_valid = 1'b1;
                        res_data_next.done_id    = run_id_reg;
                        res_data_next.done_time  = run_stamp_reg;
                    end
                    if (run_valid_reg && !run_done)
                    begin
                        have_next = 1'b1;
                        if (ring_empty)
                        begin
                            nxt.id   = run_id_reg;
                            nxt.left = run_left_reg;
                        end
                        else
                        begin
                            pop           = 1'b1;
                            nxt           = head_ent;
                            push          = 1'b1;
                            push_ent.id   = run_id_reg;
                            push_ent.left = run_left_reg;
                        end
                    end
                    else if (!ring_empty)
                    begin
                        pop       = 1'b1;
                        have_next = 1'b1;
                        nxt       = head_ent;
                    end
                    run_valid_next = have_next;
                    if (have_next)
                    begin
                        run_id_next             = nxt.id;
                        run_left_next           = left_dec;
                        run_stamp_next          = tick_next;
                        res_data_next.ran_valid = 1'b1;
                        res_data_next.ran_id    = nxt.id;
                        res_data_next.ran_left  = left_dec;
                    end
                end
                default:
                begin
                end
            endcase
        end

        head_next = pop  ? ptr_inc(head_reg) : head_reg;
        tail_next = push ? ptr_inc(tail_reg) : tail_reg;

        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase

        res_data_next.all_idle = (count_next == '0) && !run_valid_next;

        if (take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ring_mem[tail_reg] <= push_ent;
        end
        rd_data_reg  <= ring_mem[head_next];
        byp_data_reg <= push_ent;
        if (take)
        begin
            res_data_reg <= res_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_left_reg  <= '0;
            run_stamp_reg <= '0;
            tick_reg      <= '0;
            byp_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_id_reg    <= run_id_next;
            run_left_reg  <= run_left_next;
            run_stamp_reg <= run_stamp_next;
            tick_reg      <= tick_next;
            byp_reg       <= push && (tail_reg == head_next);
            res_valid_reg <= res_valid_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.load_accepted = res_data_reg.load_accepted;
    assign res.ran_valid     = res_data_reg.ran_valid;
    assign res.ran_id        = res_data_reg.ran_id;
    assign res.ran_left      = res_data_reg.ran_left;
    assign res.done_valid    = res_data_reg.done_valid;
    assign res.done_id       = res_data_reg.done_id;
    assign res.done_time     = res_data_reg.done_time;
    assign res.all_idle      = res_data_reg.all_idle;

endmodule

// ===== tb/rrts_schedule_checker.sv =====
`timescale 1ns / 1ps

module rrts_schedule_checker
    import rrts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 128,
    parameter int MAX_BURST   = 3600
) (
    input  logic clk,
    input  logic rst_n,
    rrts_in_if   cmd,
    rrts_out_if  res,
    output int   mismatches,
    output int   pending
);

    logic [ID_W-1:0]   ready_ids  [QUEUE_DEPTH];
    logic [LEFT_W-1:0] ready_work [QUEUE_DEPTH];
    int                ready_head  = 0;
    int                ready_tail  = 0;
    int                ready_count = 0;
    logic              run_busy  = 1'b0;
    logic [ID_W-1:0]   run_task  = '0;
    logic [LEFT_W-1:0] run_work  = '0;
    logic [TIME_W-1:0] run_stamp = '0;
    logic [TIME_W-1:0] now_tick  = '0;

    result_t expected_results [$];
    result_t want;
    int      fail_count = 0;
    int      queue_len  = 0;

    assign mismatches = fail_count;
    assign pending    = queue_len;

    function automatic void ring_push(logic [ID_W-1:0] id, logic [LEFT_W-1:0] work);
        ready_ids[ready_tail]  = id;
        ready_work[ready_tail] = work;
        ready_tail  = (ready_tail + 1) % QUEUE_DEPTH;
        ready_count = ready_count + 1;
    endfunction

    function automatic void ring_pop(output logic [ID_W-1:0] id,
                                     output logic [LEFT_W-1:0] work);
        id   = ready_ids[ready_head];
        work = ready_work[ready_head];
        ready_head  = (ready_head + 1) % QUEUE_DEPTH;
        ready_count = ready_count - 1;
    endfunction

    function automatic result_t schedule_step(opcode_t op, logic [ID_W-1:0] id,
                                              logic [LEFT_W-1:0] burst);
        result_t           r;
        logic              have_next;
        logic [ID_W-1:0]   next_id;
        logic [LEFT_W-1:0] next_work;
        r         = '0;
        have_next = 1'b0;
        next_id   = '0;
        next_work = '0;
        if (op == OP_LOAD)
        begin
            if (ready_count < QUEUE_DEPTH)
            begin
                if (burst == 0)
                    burst = LEFT_W'(1);
                if (burst > MAX_BURST)
                    burst = LEFT_W'(MAX_BURST);
                ring_push(id, burst);
                r.load_accepted = 1'b1;
            end
        end
        else
        begin
            now_tick = now_tick + 1'b1;
            if (run_busy)
            begin
                if (run_work == 0)
                begin
                    r.done_valid = 1'b1;
                    r.done_id    = run_task;
                    r.done_time  = run_stamp;
                end
                else if (ready_count == 0)
                begin
                    next_id   = run_task;
                    next_work = run_work;
                    have_next = 1'b1;
                end
                else
                begin
                    ring_pop(next_id, next_work);
                    have_next = 1'b1;
                    ring_push(run_task, run_work);
                end
                run_busy = 1'b0;
            end
            if (!have_next && ready_count != 0)
            begin
                ring_pop(next_id, next_work);
                have_next = 1'b1;
            end
            if (have_next)
            begin
                if (next_work != 0)
                    next_work = next_work - 1'b1;
                run_busy   = 1'b1;
                run_task   = next_id;
                run_work   = next_work;
                run_stamp  = now_tick;
                r.ran_valid = 1'b1;
                r.ran_id    = next_id;
                r.ran_left  = next_work;
            end
        end
        r.all_idle = (ready_count == 0) && !run_busy;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            fail_count = fail_count + 1;
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_head  = 0;
            ready_tail  = 0;
            ready_count = 0;
            run_busy    = 1'b0;
            run_task    = '0;
            run_work    = '0;
            run_stamp   = '0;
            now_tick    = '0;
            expected_results.delete();
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                expected_results.push_back(schedule_step(opcode_t'(cmd.opcode),
                                                         cmd.task_id, cmd.burst_len));
            if (res.valid && res.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    $display("%0t: result beat with nothing expected", $time);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("load_accepted", 32'(want.load_accepted),
                                32'(res.load_accepted));
                    check_field("ran_valid", 32'(want.ran_valid), 32'(res.ran_valid));
                    check_field("ran_id", 32'(want.ran_id), 32'(res.ran_id));
                    check_field("ran_left", 32'(want.ran_left), 32'(res.ran_left));
                    check_field("done_valid", 32'(want.done_valid), 32'(res.done_valid));
                    check_field("done_id", 32'(want.done_id), 32'(res.done_id));
                    check_field("done_time", 32'(want.done_time), 32'(res.done_time));
                    check_field("all_idle", 32'(want.all_idle), 32'(res.all_idle));
                end
            end
        end
        queue_len = expected_results.size();
    end

endmodule

// ===== tb/round_robin_tick_scheduler_tb.sv =====
`timescale 1ns / 1ps

module round_robin_tick_scheduler_tb;
    import rrts_pkg::*;

    localparam int QUEUE_DEPTH = 128;
    localparam int MAX_BURST   = 3600;

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   sink_idle_pct;
    int   items_sent;
    int   mismatches;
    int   pending;

    rrts_in_if  cmd_if ();
    rrts_out_if res_if ();

    round_robin_tick_scheduler #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .res   (res_if)
    );

    rrts_schedule_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_BURST   (MAX_BURST)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd_if),
        .res        (res_if),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
        res_if.ready = 1'b0;

    always @(negedge clk)
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic send_cmd(opcode_t op, logic [ID_W-1:0] id, logic [LEFT_W-1:0] burst);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_if.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.opcode    <= op;
        cmd_if.task_id   <= id;
        cmd_if.burst_len <= burst;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent = items_sent + 1;
        @(negedge clk);
    endtask

    task automatic load_task(logic [ID_W-1:0] id, logic [LEFT_W-1:0] burst);
        send_cmd(OP_LOAD, id, burst);
    endtask

    task automatic tick();
        send_cmd(OP_TICK, ID_W'($urandom_range(127)), LEFT_W'($urandom_range(4095)));
    endtask

    // well-formed load/tick runs with short bursts, mixed with random beats
    task automatic run_episodes(int budget);
        int stop_at;
        int n;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9) < 6)
            begin
                n = $urandom_range(5, 1);
                repeat (n) load_task(ID_W'($urandom_range(127)), LEFT_W'($urandom_range(6)));
                n = $urandom_range(20, 1);
                repeat (n) tick();
            end
            else
            begin
                n = $urandom_range(8, 1);
                repeat (n)
                    send_cmd(opcode_t'($urandom_range(1)), ID_W'($urandom_range(127)),
                             LEFT_W'($urandom_range(6)));
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        sender_idle_pct  = 24;
        sink_idle_pct    = 66;
        items_sent       = 0;
        cmd_if.valid     = 1'b0;
        cmd_if.opcode    = OP_LOAD;
        cmd_if.task_id   = '0;
        cmd_if.burst_len = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tick();
        load_task(7'd127, 12'd3);
        repeat (4) tick();
        tick();
        load_task(7'd0, 12'd0);
        load_task(7'd85, 12'd2);
        load_task(7'd42, 12'd1);
        repeat (4) tick();
        load_task(7'd127, 12'd1);
        repeat (2) tick();

        // fill the ring past full, then tick with it full and the run task unfinished
        for (int i = 0; i < QUEUE_DEPTH + 3; i++)
            load_task(ID_W'($urandom_range(127)), (i < 4) ? 12'd3 : 12'd1);
        tick();
        load_task(ID_W'($urandom_range(127)), 12'd2);
        tick();
        tick();
        run_episodes(380);

        sender_idle_pct = 66;
        sink_idle_pct   = 24;
        run_episodes(380);

        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        load_task(7'd127, 12'd4095);
        load_task(7'd0, 12'd3600);
        load_task(7'd85, 12'hAAA);
        load_task(7'd42, 12'h555);
        load_task(7'd1, 12'd0);
        load_task(7'd126, 12'd3601);
        // rotate the saturated and odd bursts through the ring
        repeat (50) tick();

        cmd_if.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("round_robin_tick_scheduler_tb OK");
        else
            $display("round_robin_tick_scheduler_tb NOT OK");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("round_robin_tick_scheduler_tb NOT OK");
        $finish;
    end

endmodule
